FILE: sv/ps2kc_pkg.sv
`timescale 1ns / 1ps

package ps2kc_pkg;

    // Port access kinds
    localparam logic [1:0] OP_READ_DATA   = 2'd0;
    localparam logic [1:0] OP_WRITE_DATA  = 2'd1;
    localparam logic [1:0] OP_READ_STATUS = 2'd2;
    localparam logic [1:0] OP_WRITE_CMD   = 2'd3;

    // What the next data port write is taken as
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_CONFIG  = 2'd1;
    localparam logic [1:0] KIND_OUTPORT = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNHANDLED = 2'd1;
    localparam logic [1:0] ERR_SCAN_SET  = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

    // Controller commands
    localparam logic [7:0] CMD_READ_CFG    = 8'h20;
    localparam logic [7:0] CMD_WRITE_CFG   = 8'h60;
    localparam logic [7:0] CMD_AUX_DIS     = 8'hA7;
    localparam logic [7:0] CMD_AUX_EN      = 8'hA8;
    localparam logic [7:0] CMD_SELF_TEST   = 8'hAA;
    localparam logic [7:0] CMD_IF_TEST     = 8'hAB;
    localparam logic [7:0] CMD_KBD_DIS     = 8'hAD;
    localparam logic [7:0] CMD_KBD_EN      = 8'hAE;
    localparam logic [7:0] CMD_READ_OUTP   = 8'hD0;
    localparam logic [7:0] CMD_WRITE_OUTP  = 8'hD1;

    // Keyboard device bytes
    localparam logic [7:0] DEV_SCAN_SET    = 8'hF0;
    localparam logic [7:0] DEV_ENABLE      = 8'hF4;
    localparam logic [7:0] DEV_DISABLE     = 8'hF5;
    localparam logic [7:0] DEV_RESET       = 8'hFF;
    localparam logic [7:0] DEV_SET_TWO     = 8'h02;

    // Response bytes
    localparam logic [7:0] RSP_ACK         = 8'hFA;
    localparam logic [7:0] RSP_BAT_OK      = 8'hAA;
    localparam logic [7:0] RSP_TEST_OK     = 8'h55;
    localparam logic [7:0] RSP_IF_OK       = 8'h00;
    localparam logic [7:0] RSP_EMPTY       = 8'hFF;

    // Config byte bits
    localparam int CFG_IRQ_BIT    = 0;
    localparam int CFG_AUX_BIT    = 1;
    localparam int CFG_DEVICE_BIT = 5;

    // Status byte bits
    localparam int STS_OBF_BIT = 0;
    localparam int STS_SYS_BIT = 2;

    typedef struct packed {
        logic       system_flag;
        logic [7:0] ctrl_config;
        logic [7:0] outport;
        logic [1:0] pending_kind;
        logic       awaiting_set;
    } t_state;

    typedef struct packed {
        logic       push0;
        logic [7:0] data0;
        logic       push1;
        logic [7:0] data1;
        logic       pop;
    } t_fifo_req;

    typedef struct packed {
        logic [7:0] head_data;
        logic       empty;
        logic       free1;
        logic       free2;
    } t_fifo_stat;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       irq_pulse;
        logic [1:0] error_code;
    } t_result;

endpackage

FILE: sv/ps2kc_cmd_if.sv
`timescale 1ns / 1ps

interface ps2kc_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] write_byte;

    modport source (output valid, output opcode, output write_byte, input ready);
    modport sink   (input valid, input opcode, input write_byte, output ready);
endinterface

FILE: sv/ps2kc_rsp_if.sv
`timescale 1ns / 1ps

interface ps2kc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       irq_pulse;
    logic [1:0] error_code;

    modport source (output valid, output read_byte, output irq_pulse, output error_code,
                    input ready);
    modport sink   (input valid, input read_byte, input irq_pulse, input error_code,
                    output ready);
endinterface

FILE: sv/ps2kc_fifo.sv
`timescale 1ns / 1ps

module ps2kc_fifo #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ps2kc_pkg::t_fifo_req  i_req,
    output ps2kc_pkg::t_fifo_stat o_stat
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(FIFO_DEPTH - 1);

    logic [7:0]       r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] tail_next;
    logic [PTR_W-1:0] tail_next2;

    always_comb begin
        tail_next  = (r_tail == LAST_IDX) ? '0 : r_tail + PTR_W'(1);
        tail_next2 = (tail_next == LAST_IDX) ? '0 : tail_next + PTR_W'(1);

        // advance tail by one or two slots
        n_tail = r_tail;
        if (i_req.push0 && i_req.push1) begin
            n_tail = tail_next2;
        end else if (i_req.push0) begin
            n_tail = tail_next;
        end

        n_head = r_head;
        if (i_req.pop) begin
            n_head = (r_head == LAST_IDX) ? '0 : r_head + PTR_W'(1);
        end

        n_count = r_count + CNT_W'(i_req.push0) + CNT_W'(i_req.push1)
                - CNT_W'(i_req.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.push0) begin
            r_mem[r_tail] <= i_req.data0;
        end
        if (i_req.push1) begin
            r_mem[tail_next] <= i_req.data1;
        end
    end

    assign o_stat.head_data = r_mem[r_head];
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.free1     = (r_count < CNT_W'(FIFO_DEPTH));
    assign o_stat.free2     = (r_count < CNT_W'(FIFO_DEPTH - 1));

endmodule

FILE: sv/ps2kc_decode.sv
`timescale 1ns / 1ps

module ps2kc_decode (
    input  logic                  i_en,
    input  logic [1:0]            i_opcode,
    input  logic [7:0]            i_write_byte,
    input  ps2kc_pkg::t_state     i_state,
    input  ps2kc_pkg::t_fifo_stat i_stat,
    output ps2kc_pkg::t_state     o_state,
    output ps2kc_pkg::t_fifo_req  o_req,
    output ps2kc_pkg::t_result    o_result
);

    logic       want0;
    logic       want1;
    logic [7:0] data0;
    logic       pop;
    logic       irq;
    logic       overflow;
    logic       bad_set;
    logic       unhandled;
    logic [7:0] rd;

    always_comb begin
        o_state   = i_state;
        want0     = 1'b0;
        want1     = 1'b0;
        data0     = ps2kc_pkg::RSP_ACK;
        pop       = 1'b0;
        irq       = 1'b0;
        bad_set   = 1'b0;
        unhandled = 1'b0;
        rd        = '0;

        unique case (i_opcode)
            ps2kc_pkg::OP_READ_DATA: begin
                pop = !i_stat.empty;
                rd  = i_stat.empty ? ps2kc_pkg::RSP_EMPTY : i_stat.head_data;
            end
            ps2kc_pkg::OP_READ_STATUS: begin
                rd[ps2kc_pkg::STS_OBF_BIT] = !i_stat.empty;
                rd[ps2kc_pkg::STS_SYS_BIT] = i_state.system_flag;
            end
            ps2kc_pkg::OP_WRITE_DATA: begin
                o_state.pending_kind = ps2kc_pkg::KIND_NONE;
                if (i_state.pending_kind == ps2kc_pkg::KIND_CONFIG) begin
                    o_state.ctrl_config = i_write_byte;
                end else if (i_state.pending_kind == ps2kc_pkg::KIND_OUTPORT) begin
                    o_state.outport = i_write_byte;
                end else if (i_state.ctrl_config[ps2kc_pkg::CFG_DEVICE_BIT]) begin
                    // device answers every byte with an ACK first
                    want0 = 1'b1;
                    irq   = i_state.ctrl_config[ps2kc_pkg::CFG_IRQ_BIT];
                    if (i_state.awaiting_set) begin
                        bad_set              = (i_write_byte != ps2kc_pkg::DEV_SET_TWO);
                        o_state.awaiting_set = 1'b0;
                    end else begin
                        case (i_write_byte)
                            ps2kc_pkg::DEV_SCAN_SET: o_state.awaiting_set = 1'b1;
                            ps2kc_pkg::DEV_ENABLE,
                            ps2kc_pkg::DEV_DISABLE: ;
                            ps2kc_pkg::DEV_RESET: begin
                                o_state.system_flag = 1'b0;
                                want1               = 1'b1;
                            end
                            default: unhandled = 1'b1;
                        endcase
                    end
                end else begin
                    unhandled = 1'b1;
                end
            end
            ps2kc_pkg::OP_WRITE_CMD: begin
                unique case (i_write_byte)
                    ps2kc_pkg::CMD_READ_CFG: begin
                        want0 = 1'b1;
                        data0 = i_state.ctrl_config;
                    end
                    ps2kc_pkg::CMD_WRITE_CFG:
                        o_state.pending_kind = ps2kc_pkg::KIND_CONFIG;
                    ps2kc_pkg::CMD_AUX_DIS:
                        o_state.ctrl_config[ps2kc_pkg::CFG_AUX_BIT] = 1'b0;
                    ps2kc_pkg::CMD_AUX_EN:
                        o_state.ctrl_config[ps2kc_pkg::CFG_AUX_BIT] = 1'b1;
                    ps2kc_pkg::CMD_SELF_TEST: begin
                        o_state.system_flag = 1'b0;
                        want0               = 1'b1;
                        data0               = ps2kc_pkg::RSP_TEST_OK;
                    end
                    ps2kc_pkg::CMD_IF_TEST: begin
                        want0 = 1'b1;
                        data0 = ps2kc_pkg::RSP_IF_OK;
                    end
                    ps2kc_pkg::CMD_KBD_DIS:
                        o_state.ctrl_config[ps2kc_pkg::CFG_IRQ_BIT] = 1'b0;
                    ps2kc_pkg::CMD_KBD_EN:
                        o_state.ctrl_config[ps2kc_pkg::CFG_IRQ_BIT] = 1'b1;
                    ps2kc_pkg::CMD_READ_OUTP: begin
                        want0 = 1'b1;
                        data0 = i_state.outport;
                    end
                    ps2kc_pkg::CMD_WRITE_OUTP:
                        o_state.pending_kind = ps2kc_pkg::KIND_OUTPORT;
                    default: unhandled = 1'b1;
                endcase
                irq = want0 && i_state.ctrl_config[ps2kc_pkg::CFG_IRQ_BIT];
            end
        endcase

        // drop bytes that find no room
        overflow = (want0 && !i_stat.free1) || (want1 && !i_stat.free2);

        o_req.push0 = i_en && want0 && i_stat.free1;
        o_req.data0 = data0;
        o_req.push1 = i_en && want1 && i_stat.free2;
        o_req.data1 = ps2kc_pkg::RSP_BAT_OK;
        o_req.pop   = i_en && pop;

        o_result.read_byte = rd;
        o_result.irq_pulse = irq;
        if (overflow) begin
            o_result.error_code = ps2kc_pkg::ERR_OVERFLOW;
        end else if (bad_set) begin
            o_result.error_code = ps2kc_pkg::ERR_SCAN_SET;
        end else if (unhandled) begin
            o_result.error_code = ps2kc_pkg::ERR_UNHANDLED;
        end else begin
            o_result.error_code = ps2kc_pkg::ERR_NONE;
        end
    end

endmodule

FILE: sv/ps2_keyboard_controller_top.sv
`timescale 1ns / 1ps

// 8042-style keyboard controller, one port access per beat.
//
// i_cmd (sink): one beat per port access. opcode selects data read, data
// write, status read or command write; write_byte carries the written byte.
// o_rsp (source): exactly one beat per access, in order, with the read byte
// (zero for writes), the IRQ1 pulse and an error code.
//
// An accepted beat lands in an input register; once the result register is
// free or being taken, it is decoded, which updates the controller state and
// the response FIFO and loads the result register. With o_rsp.ready high a
// new access is taken every cycle; the decode itself is combinational.
//
// Reset (synchronous, active low) sets config and output port to 0x01,
// raises the system flag, clears the pending write kind and the scan-set
// wait, and empties the FIFO. Stored FIFO bytes are not cleared.
//
// When o_rsp is stalled the result register holds and the input register
// keeps one more access; i_cmd.ready drops once both are full.

module ps2_keyboard_controller_top #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ps2kc_cmd_if.sink    i_cmd,
    ps2kc_rsp_if.source  o_rsp
);

    // input register
    logic       r_in_valid;
    logic [1:0] r_op;
    logic [7:0] r_byte;

    // result register
    logic                r_out_valid;
    ps2kc_pkg::t_result  r_result;

    // controller state
    ps2kc_pkg::t_state   r_state;
    ps2kc_pkg::t_state   n_state;

    ps2kc_pkg::t_fifo_req  fifo_req;
    ps2kc_pkg::t_fifo_stat fifo_stat;
    ps2kc_pkg::t_result    n_result;

    logic advance;
    logic proc;

    // result slot frees up when empty or being taken
    assign advance     = !r_out_valid || o_rsp.ready;
    assign proc        = r_in_valid && advance;
    assign i_cmd.ready = !r_in_valid || advance;

    ps2kc_decode u_decode (
        .i_en         (proc),
        .i_opcode     (r_op),
        .i_write_byte (r_byte),
        .i_state      (r_state),
        .i_stat       (fifo_stat),
        .o_state      (n_state),
        .o_req        (fifo_req),
        .o_result     (n_result)
    );

    ps2kc_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fifo_req),
        .o_stat  (fifo_stat)
    );

    // Input register: load on accept, drain when decoded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_op   <= i_cmd.opcode;
            r_byte <= i_cmd.write_byte;
        end
    end

    // Controller state advances only when an access is decoded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.system_flag  <= 1'b1;
            r_state.ctrl_config  <= 8'h01;
            r_state.outport      <= 8'h01;
            r_state.pending_kind <= ps2kc_pkg::KIND_NONE;
            r_state.awaiting_set <= 1'b0;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    // Result register: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_result <= n_result;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_byte  = r_result.read_byte;
    assign o_rsp.irq_pulse  = r_result.irq_pulse;
    assign o_rsp.error_code = r_result.error_code;

    // Reading an empty FIFO must leave it empty.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_op == ps2kc_pkg::OP_READ_DATA && fifo_stat.empty
        |=> fifo_stat.empty)
        else $error("empty data read changed FIFO fill");

    // A held access must not be overwritten while the result side stalls.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance
        |=> r_in_valid && $stable(r_op) && $stable(r_byte))
        else $error("pending access lost during stall");

    // IRQ1 only on writes, and only with interrupts enabled in config.
    a_irq_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && n_result.irq_pulse
        |-> (r_op == ps2kc_pkg::OP_WRITE_DATA || r_op == ps2kc_pkg::OP_WRITE_CMD)
            && r_state.ctrl_config[ps2kc_pkg::CFG_IRQ_BIT])
        else $error("IRQ1 raised without a write or with IRQ disabled");

    // Two free slots imply one free slot.
    a_free_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_stat.free2 |-> fifo_stat.free1)
        else $error("FIFO space flags inconsistent");

endmodule

FILE: verif/ps2_keyboard_controller_top_test.sv
`timescale 1ns / 1ps

module ps2_keyboard_controller_top_test;

    localparam int DEPTH            = 16;
    localparam int RANDOM_ITEMS     = 1700;
    localparam int CALM_ITEMS       = 250;    // tail of the run with no idling
    localparam int LONG_HOLD_AT     = 600;    // results seen before the long stall
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT      = 3000;   // cycles without any beat
    localparam int TAIL_CYCLES      = 10;
    localparam int MAX_PRINTED      = 50;

    typedef struct {
        logic [1:0] op;
        logic [7:0] b;
        bit         drain;    // hold this access until every result is back
    } t_port_access;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ps2kc_cmd_if cmd_bus ();
    ps2kc_rsp_if rsp_bus ();

    ps2_keyboard_controller_top #(
        .FIFO_DEPTH(DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_bus),
        .o_rsp  (rsp_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Controller state as the testbench sees it
    // ------------------------------------------------------------------
    logic       sysf      = 1'b1;
    logic [7:0] cfg_byte  = 8'h01;
    logic [7:0] outp_byte = 8'h01;
    logic [1:0] wr_kind   = ps2kc_pkg::KIND_NONE;
    logic       want_set  = 1'b0;
    logic [7:0] rsp_fifo [DEPTH];
    int         rd_ptr    = 0;
    int         wr_ptr    = 0;
    int         fill      = 0;

    t_port_access         access_q [$];
    ps2kc_pkg::t_result   due_results [$];
    t_port_access         next_access;
    ps2kc_pkg::t_result   got_exp;

    int n_accepted   = 0;
    int results_seen = 0;     // updated with NBA so the driver sees a stable value
    int total_items  = 0;
    int n_fail       = 0;
    int send_gap     = 0;
    int hold_cnt     = 0;
    bit long_hold_done = 1'b0;

    function automatic logic [1:0] worst(logic [1:0] a, logic [1:0] b);
        return (a > b) ? a : b;
    endfunction

    // Push one response byte; drop it when the FIFO is full.
    function automatic logic [1:0] queue_byte(logic [7:0] v);
        if (fill >= DEPTH) return ps2kc_pkg::ERR_OVERFLOW;
        rsp_fifo[wr_ptr] = v;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        fill++;
        return ps2kc_pkg::ERR_NONE;
    endfunction

    // Apply one port access to the predicted state and return its result.
    function automatic ps2kc_pkg::t_result kbc_access(logic [1:0] op, logic [7:0] b);
        ps2kc_pkg::t_result r;
        logic [1:0]         e;
        r = '0;
        e = ps2kc_pkg::ERR_NONE;
        case (op)
            ps2kc_pkg::OP_READ_DATA: begin
                if (fill != 0) begin
                    r.read_byte = rsp_fifo[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    fill--;
                end else begin
                    r.read_byte = ps2kc_pkg::RSP_EMPTY;
                end
            end
            ps2kc_pkg::OP_READ_STATUS: begin
                r.read_byte[ps2kc_pkg::STS_OBF_BIT] = (fill != 0);
                r.read_byte[ps2kc_pkg::STS_SYS_BIT] = sysf;
            end
            ps2kc_pkg::OP_WRITE_DATA: begin
                if (wr_kind == ps2kc_pkg::KIND_CONFIG) begin
                    cfg_byte = b;
                    wr_kind  = ps2kc_pkg::KIND_NONE;
                end else if (wr_kind == ps2kc_pkg::KIND_OUTPORT) begin
                    outp_byte = b;
                    wr_kind   = ps2kc_pkg::KIND_NONE;
                end else begin
                    wr_kind = ps2kc_pkg::KIND_NONE;
                    if (cfg_byte[ps2kc_pkg::CFG_DEVICE_BIT]) begin
                        // the device acks every byte before acting on it
                        e = queue_byte(ps2kc_pkg::RSP_ACK);
                        if (want_set) begin
                            if (b != ps2kc_pkg::DEV_SET_TWO)
                                e = worst(e, ps2kc_pkg::ERR_SCAN_SET);
                            want_set = 1'b0;
                        end else begin
                            case (b)
                                ps2kc_pkg::DEV_SCAN_SET: want_set = 1'b1;
                                ps2kc_pkg::DEV_ENABLE, ps2kc_pkg::DEV_DISABLE: begin
                                end
                                ps2kc_pkg::DEV_RESET: begin
                                    sysf = 1'b0;
                                    e = worst(e, queue_byte(ps2kc_pkg::RSP_BAT_OK));
                                end
                                default: e = worst(e, ps2kc_pkg::ERR_UNHANDLED);
                            endcase
                        end
                        r.irq_pulse  = cfg_byte[ps2kc_pkg::CFG_IRQ_BIT];
                        r.error_code = e;
                    end else begin
                        r.error_code = ps2kc_pkg::ERR_UNHANDLED;
                    end
                end
            end
            default: begin
                case (b)
                    ps2kc_pkg::CMD_READ_CFG: begin
                        r.error_code = queue_byte(cfg_byte);
                        r.irq_pulse  = cfg_byte[ps2kc_pkg::CFG_IRQ_BIT];
                    end
                    ps2kc_pkg::CMD_WRITE_CFG: wr_kind = ps2kc_pkg::KIND_CONFIG;
                    ps2kc_pkg::CMD_AUX_DIS:   cfg_byte[ps2kc_pkg::CFG_AUX_BIT] = 1'b0;
                    ps2kc_pkg::CMD_AUX_EN:    cfg_byte[ps2kc_pkg::CFG_AUX_BIT] = 1'b1;
                    ps2kc_pkg::CMD_SELF_TEST: begin
                        sysf = 1'b0;
                        r.error_code = queue_byte(ps2kc_pkg::RSP_TEST_OK);
                        r.irq_pulse  = cfg_byte[ps2kc_pkg::CFG_IRQ_BIT];
                    end
                    ps2kc_pkg::CMD_IF_TEST: begin
                        r.error_code = queue_byte(ps2kc_pkg::RSP_IF_OK);
                        r.irq_pulse  = cfg_byte[ps2kc_pkg::CFG_IRQ_BIT];
                    end
                    ps2kc_pkg::CMD_KBD_DIS:   cfg_byte[ps2kc_pkg::CFG_IRQ_BIT] = 1'b0;
                    ps2kc_pkg::CMD_KBD_EN:    cfg_byte[ps2kc_pkg::CFG_IRQ_BIT] = 1'b1;
                    ps2kc_pkg::CMD_READ_OUTP: begin
                        r.error_code = queue_byte(outp_byte);
                        r.irq_pulse  = cfg_byte[ps2kc_pkg::CFG_IRQ_BIT];
                    end
                    ps2kc_pkg::CMD_WRITE_OUTP: wr_kind = ps2kc_pkg::KIND_OUTPORT;
                    default: r.error_code = ps2kc_pkg::ERR_UNHANDLED;
                endcase
            end
        endcase
        return r;
    endfunction

    task automatic log_mismatch(string what);
        if (n_fail < MAX_PRINTED) $display("mismatch at result %0d: %s", results_seen, what);
        n_fail++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic add(logic [1:0] op, logic [7:0] b, bit drain = 1'b0);
        t_port_access a;
        a.op    = op;
        a.b     = b;
        a.drain = drain;
        access_q.push_back(a);
    endtask

    function automatic logic [7:0] any_push_cmd();
        case ($urandom_range(0, 3))
            0:       return ps2kc_pkg::CMD_READ_CFG;
            1:       return ps2kc_pkg::CMD_SELF_TEST;
            2:       return ps2kc_pkg::CMD_IF_TEST;
            default: return ps2kc_pkg::CMD_READ_OUTP;
        endcase
    endfunction

    // Config byte with the device path on most of the time.
    task automatic add_cfg_write();
        logic [7:0] cb;
        cb = 8'($urandom);
        if ($urandom_range(0, 3) != 0) cb[ps2kc_pkg::CFG_DEVICE_BIT] = 1'b1;
        add(ps2kc_pkg::OP_WRITE_CMD, ps2kc_pkg::CMD_WRITE_CFG);
        add(ps2kc_pkg::OP_WRITE_DATA, cb);
    endtask

    task automatic add_device_seq();
        logic [7:0] db;
        if ($urandom_range(0, 3) == 0) add_cfg_write();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                add(ps2kc_pkg::OP_WRITE_DATA, ps2kc_pkg::DEV_SCAN_SET);
                db = 8'($urandom);
                add(ps2kc_pkg::OP_WRITE_DATA,
                    ($urandom_range(0, 3) != 0) ? ps2kc_pkg::DEV_SET_TWO : db);
            end
            4:       add(ps2kc_pkg::OP_WRITE_DATA, ps2kc_pkg::DEV_ENABLE);
            5:       add(ps2kc_pkg::OP_WRITE_DATA, ps2kc_pkg::DEV_DISABLE);
            6:       add(ps2kc_pkg::OP_WRITE_DATA, ps2kc_pkg::DEV_RESET);
            default: begin
                db = 8'($urandom);
                add(ps2kc_pkg::OP_WRITE_DATA, db);
            end
        endcase
    endtask

    task automatic add_random_seq();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            n = $urandom_range(1, 4);
            repeat (n) add(ps2kc_pkg::OP_READ_DATA, 8'($urandom));
        end else if (pick < 17) begin
            add(ps2kc_pkg::OP_READ_STATUS, 8'($urandom));
        end else if (pick < 25) begin
            add_cfg_write();
        end else if (pick < 29) begin
            add(ps2kc_pkg::OP_WRITE_CMD, ps2kc_pkg::CMD_WRITE_OUTP);
            add(ps2kc_pkg::OP_WRITE_DATA, 8'($urandom));
        end else if (pick < 41) begin
            add(ps2kc_pkg::OP_WRITE_CMD, any_push_cmd());
        end else if (pick < 47) begin
            case ($urandom_range(0, 3))
                0:       add(ps2kc_pkg::OP_WRITE_CMD, ps2kc_pkg::CMD_AUX_DIS);
                1:       add(ps2kc_pkg::OP_WRITE_CMD, ps2kc_pkg::CMD_AUX_EN);
                2:       add(ps2kc_pkg::OP_WRITE_CMD, ps2kc_pkg::CMD_KBD_DIS);
                default: add(ps2kc_pkg::OP_WRITE_CMD, ps2kc_pkg::CMD_KBD_EN);
            endcase
        end else if (pick < 71) begin
            add_device_seq();
        end else if (pick < 76) begin
            // flood past the FIFO depth to hit overflow, then drain it
            n = $urandom_range(DEPTH + 1, DEPTH + 4);
            repeat (n) add(ps2kc_pkg::OP_WRITE_CMD, any_push_cmd());
            repeat (DEPTH + 2) add(ps2kc_pkg::OP_READ_DATA, 8'($urandom));
        end else if (pick < 85) begin
            n = $urandom_range(8, 20);
            repeat (n) add(ps2kc_pkg::OP_READ_DATA, 8'($urandom));
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) add(2'($urandom_range(0, 3)), 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued accesses, predict each accepted beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_bus.valid      <= 1'b0;
            cmd_bus.opcode     <= ps2kc_pkg::OP_READ_DATA;
            cmd_bus.write_byte <= 8'h00;
            send_gap = 0;
        end else begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                due_results.push_back(kbc_access(cmd_bus.opcode, cmd_bus.write_byte));
                n_accepted++;
            end
            // the slot is free once the current beat is taken or none is offered
            if (!cmd_bus.valid || cmd_bus.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_bus.valid <= 1'b0;
                end else if (access_q.size() == 0) begin
                    cmd_bus.valid <= 1'b0;
                end else if (access_q[0].drain && n_accepted != results_seen) begin
                    // hold until the block has answered everything
                    cmd_bus.valid <= 1'b0;
                end else if (access_q.size() > CALM_ITEMS && $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(0, 14);
                    cmd_bus.valid <= 1'b0;
                end else begin
                    next_access = access_q.pop_front();
                    cmd_bus.valid      <= 1'b1;
                    cmd_bus.opcode     <= next_access.op;
                    cmd_bus.write_byte <= next_access.b;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result beat, stall the response side at random
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (due_results.size() == 0) begin
                    log_mismatch("result beat with nothing expected");
                end else begin
                    got_exp = due_results.pop_front();
                    if (rsp_bus.read_byte !== got_exp.read_byte)
                        log_mismatch($sformatf("read_byte %h, expected %h",
                                               rsp_bus.read_byte, got_exp.read_byte));
                    if (rsp_bus.irq_pulse !== got_exp.irq_pulse)
                        log_mismatch($sformatf("irq_pulse %b, expected %b",
                                               rsp_bus.irq_pulse, got_exp.irq_pulse));
                    if (rsp_bus.error_code !== got_exp.error_code)
                        log_mismatch($sformatf("error_code %0d, expected %0d",
                                               rsp_bus.error_code, got_exp.error_code));
                end
                results_seen <= results_seen + 1;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                rsp_bus.ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
                // long back-pressure: let the block fill up and stall its input
                long_hold_done = 1'b1;
                hold_cnt = LONG_HOLD_CYCLES - 1;
                rsp_bus.ready <= 1'b0;
            end else if (results_seen < total_items - CALM_ITEMS &&
                         $urandom_range(0, 11) == 0) begin
                hold_cnt = $urandom_range(0, 14);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no beat moves for too long
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("** ps2_keyboard_controller_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int base;
        bit mid_drain;
        // known values before the first edge
        i_rst_n            = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.opcode     = ps2kc_pkg::OP_READ_DATA;
        cmd_bus.write_byte = 8'h00;
        rsp_bus.ready      = 1'b0;
        mid_drain          = 1'b0;

        // directed: every command, the device bytes and the special cases
        add(ps2kc_pkg::OP_READ_STATUS, 8'h00);
        add(ps2kc_pkg::OP_READ_DATA,   8'hFF);           // empty FIFO read
        add(ps2kc_pkg::OP_WRITE_CMD,   ps2kc_pkg::CMD_READ_CFG);
        add(ps2kc_pkg::OP_WRITE_CMD,   ps2kc_pkg::CMD_SELF_TEST);
        add(ps2kc_pkg::OP_WRITE_CMD,   ps2kc_pkg::CMD_IF_TEST);
        add(ps2kc_pkg::OP_WRITE_CMD,   ps2kc_pkg::CMD_READ_OUTP);
        add(ps2kc_pkg::OP_WRITE_CMD,   8'h3C);           // unknown command
        add(ps2kc_pkg::OP_WRITE_DATA,  8'h5A);           // data write, device path off
        add(ps2kc_pkg::OP_WRITE_CMD,   ps2kc_pkg::CMD_AUX_EN);
        add(ps2kc_pkg::OP_WRITE_CMD,   ps2kc_pkg::CMD_AUX_DIS);
        add(ps2kc_pkg::OP_WRITE_CMD,   ps2kc_pkg::CMD_KBD_DIS);
        add(ps2kc_pkg::OP_WRITE_CMD,   ps2kc_pkg::CMD_KBD_EN);
        add(ps2kc_pkg::OP_WRITE_CMD,   ps2kc_pkg::CMD_WRITE_CFG);
        add(ps2kc_pkg::OP_WRITE_DATA,  8'h21);           // IRQ on, device path on
        add(ps2kc_pkg::OP_WRITE_DATA,  ps2kc_pkg::DEV_SCAN_SET);
        add(ps2kc_pkg::OP_WRITE_DATA,  8'h07);           // bad scan-code set
        add(ps2kc_pkg::OP_WRITE_DATA,  ps2kc_pkg::DEV_SCAN_SET);
        add(ps2kc_pkg::OP_WRITE_DATA,  ps2kc_pkg::DEV_SET_TWO);
        add(ps2kc_pkg::OP_WRITE_DATA,  ps2kc_pkg::DEV_ENABLE);
        add(ps2kc_pkg::OP_WRITE_DATA,  ps2kc_pkg::DEV_DISABLE);
        add(ps2kc_pkg::OP_WRITE_DATA,  ps2kc_pkg::DEV_RESET);
        add(ps2kc_pkg::OP_WRITE_DATA,  8'h77);           // unknown device byte
        add(ps2kc_pkg::OP_WRITE_CMD,   ps2kc_pkg::CMD_WRITE_OUTP);
        add(ps2kc_pkg::OP_WRITE_DATA,  8'hFE);
        add(ps2kc_pkg::OP_READ_STATUS, 8'hFF);

        // random part; pause the sender three times until all results are back
        base = access_q.size();
        add(ps2kc_pkg::OP_READ_DATA, 8'h00, 1'b1);
        while (access_q.size() < base + RANDOM_ITEMS) begin
            if (!mid_drain && access_q.size() >= base + RANDOM_ITEMS / 2) begin
                add(ps2kc_pkg::OP_READ_STATUS, 8'($urandom), 1'b1);
                mid_drain = 1'b1;
            end
            add_random_seq();
        end
        add(ps2kc_pkg::OP_READ_STATUS, 8'h00, 1'b1);
        total_items = access_q.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every access to go out and every result to come back
        while (access_q.size() != 0 || n_accepted != total_items ||
               results_seen != total_items)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (due_results.size() != 0) log_mismatch("expected results left over");
        if (n_fail == 0)
            $display("** ps2_keyboard_controller_top: PASSED **");
        else
            $display("** ps2_keyboard_controller_top: FAILED **");
        $finish;
    end

endmodule
